// File: src/bresl_pkg.sv
// Shared constants for the Bresenham line point generator.
package bresl_pkg;

  localparam int unsigned FieldBits   = 6;   // fixed width of every coordinate field
  localparam int unsigned CoordBitsDef = 6;  // default internal coordinate width
  localparam int unsigned InDataBits  = 24;  // four fields, already whole bytes
  localparam int unsigned OutDataBits = 16;  // two fields, padded to bytes
  localparam int unsigned QueueDepth  = 2;

endpackage

// File: src/bresl_front.sv
// Front end: classifies a line request into major/minor axis setup.
module bresl_front
  import bresl_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned CMD_BITS   = 3 + 4 * COORD_BITS
) (
  input  logic [FieldBits-1:0] start_x,
  input  logic [FieldBits-1:0] start_y,
  input  logic [FieldBits-1:0] end_x,
  input  logic [FieldBits-1:0] end_y,
  output logic [CMD_BITS-1:0]  cmd
);

  localparam int unsigned CB = COORD_BITS;

  logic [CB-1:0] x0, y0, x1, y1;
  logic [CB:0]   dx, dy;
  logic [CB-1:0] adx, ady;
  logic          steep;
  logic          maj_neg, min_neg;
  logic [CB-1:0] ma0, mi0, dmaj, dmin;

  assign x0 = start_x[CB-1:0];
  assign y0 = start_y[CB-1:0];
  assign x1 = end_x[CB-1:0];
  assign y1 = end_y[CB-1:0];

  assign dx  = {1'b0, x1} - {1'b0, x0};
  assign dy  = {1'b0, y1} - {1'b0, y0};
  assign adx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
  assign ady = dy[CB] ? CB'(-dy) : dy[CB-1:0];

  // ties go to the steep (y-major) case
  assign steep   = (ady >= adx);
  assign ma0     = steep ? y0 : x0;
  assign mi0     = steep ? x0 : y0;
  assign dmaj    = steep ? ady : adx;
  assign dmin    = steep ? adx : ady;
  assign maj_neg = steep ? dy[CB] : dx[CB];
  assign min_neg = steep ? dx[CB] : dy[CB];

  assign cmd = {steep, maj_neg, min_neg, ma0, mi0, dmaj, dmin};

endmodule

// File: src/bresl_queue.sv
// Short command queue between the front end and the stepping back end.
module bresl_queue
  import bresl_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en && !full) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd_en && !empty) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CW'(wr_en && !full) - CW'(rd_en && !empty);
    end
  end

endmodule

// File: src/bresl_back.sv
// Back end: steps along the major axis and emits one point per cycle while pt_ready keeps the output free.
module bresl_back
  import bresl_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  parameter int unsigned CMD_BITS   = 3 + 4 * COORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CMD_BITS-1:0]  cmd,
  input  logic                 cmd_avail,
  output logic                 cmd_pop,
  output logic                 pt_valid,
  input  logic                 pt_ready,
  output logic [FieldBits-1:0] pt_x,
  output logic [FieldBits-1:0] pt_y,
  output logic                 pt_last,
  output logic                 pt_empty
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned EW = COORD_BITS + 3;

  logic          c_steep, c_maj_neg, c_min_neg;
  logic [CB-1:0] c_ma0, c_mi0, c_dmaj, c_dmin;
  assign {c_steep, c_maj_neg, c_min_neg, c_ma0, c_mi0, c_dmaj, c_dmin} = cmd;

  logic                 active_r, nopts_r;
  logic                 steep_r, maj_neg_r, min_neg_r;
  logic [CB-1:0]        maj_r, mnr_r, rem_r;
  logic signed [EW-1:0] err_r, two_dmin_r, two_diff_r;
  logic                 out_valid_r, out_last_r, out_empty_r;
  logic [FieldBits-1:0] out_x_r, out_y_r;

  logic                 slot_free, step;
  logic [CB-1:0]        maj_nxt, mnr_nxt;
  logic signed [EW-1:0] err_nxt;
  logic signed [EW-1:0] l_two_dmin, l_two_dmaj;
  logic                 last_pt;

  assign slot_free = !out_valid_r || pt_ready;
  assign step      = active_r && slot_free;
  assign cmd_pop   = !active_r && cmd_avail;

  assign l_two_dmin = EW'({c_dmin, 1'b0});
  assign l_two_dmaj = EW'({c_dmaj, 1'b0});

  always_comb begin
    maj_nxt = maj_neg_r ? maj_r - 1'b1 : maj_r + 1'b1;
    if (err_r > 0) begin
      err_nxt = err_r + two_diff_r;
      mnr_nxt = min_neg_r ? mnr_r - 1'b1 : mnr_r + 1'b1;
    end else begin
      err_nxt = err_r + two_dmin_r;
      mnr_nxt = mnr_r;
    end
  end

  assign last_pt = (rem_r == CB'(1));

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      steep_r    <= c_steep;
      maj_neg_r  <= c_maj_neg;
      min_neg_r  <= c_min_neg;
      maj_r      <= c_ma0;
      mnr_r      <= c_mi0;
      rem_r      <= c_dmaj - 1'b1;
      two_dmin_r <= l_two_dmin;
      two_diff_r <= l_two_dmin - l_two_dmaj;
      err_r      <= l_two_dmin - EW'(c_dmaj);
    end else if (step && !nopts_r) begin
      maj_r <= maj_nxt;
      mnr_r <= mnr_nxt;
      err_r <= err_nxt;
      rem_r <= rem_r - 1'b1;
    end
    if (step) begin
      out_last_r <= nopts_r || last_pt;
      out_empty_r <= nopts_r;
      if (nopts_r) begin
        out_x_r <= '0;
        out_y_r <= '0;
      end else begin
        out_x_r <= FieldBits'(steep_r ? mnr_nxt : maj_nxt);
        out_y_r <= FieldBits'(steep_r ? maj_nxt : mnr_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      nopts_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        active_r <= 1'b1;
        nopts_r  <= (c_dmaj < CB'(2));
      end else if (step && (nopts_r || last_pt)) begin
        active_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (pt_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign pt_valid = out_valid_r;
  assign pt_x     = out_x_r;
  assign pt_y     = out_y_r;
  assign pt_last  = out_last_r;
  assign pt_empty = out_empty_r;

endmodule

// File: src/bresenham_line_points.sv
// Top level of the Bresenham line point generator.
// A request passes the queue, then a load of the stepping unit, then a step, before its first point is valid.
// Throughput: one point per cycle while out_tready holds, with a load of the stepping unit
// between lines; a 2-entry queue absorbs requests.
// The single major-axis stepping unit in the back end sets the rate.
// Reset: synchronous active-low rst_n empties the queue and the output register.
module bresenham_line_points
  import bresl_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [InDataBits-1:0]  in_tdata,   // start_x, start_y, end_x, end_y
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OutDataBits-1:0] out_tdata,  // point_x, point_y, zero pad
  output logic                   out_tlast,  // last_point
  output logic                   out_tuser   // no_points
);

  localparam int unsigned CmdBits = 3 + 4 * COORD_BITS;

  logic [CmdBits-1:0]   cmd_in, cmd_out;
  logic                 q_full, q_empty, q_pop;
  logic [FieldBits-1:0] pt_x, pt_y;

  bresl_front #(.COORD_BITS(COORD_BITS), .CMD_BITS(CmdBits)) u_front (
    .start_x (in_tdata[FieldBits-1:0]),
    .start_y (in_tdata[2*FieldBits-1:FieldBits]),
    .end_x   (in_tdata[3*FieldBits-1:2*FieldBits]),
    .end_y   (in_tdata[4*FieldBits-1:3*FieldBits]),
    .cmd     (cmd_in)
  );

  assign in_tready = !q_full;

  bresl_queue #(.WIDTH(CmdBits), .DEPTH(QueueDepth)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_tvalid),
    .wr_data (cmd_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (cmd_out),
    .empty   (q_empty)
  );

  bresl_back #(.COORD_BITS(COORD_BITS), .CMD_BITS(CmdBits)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_avail (!q_empty),
    .cmd_pop   (q_pop),
    .pt_valid  (out_tvalid),
    .pt_ready  (out_tready),
    .pt_x      (pt_x),
    .pt_y      (pt_y),
    .pt_last   (out_tlast),
    .pt_empty  (out_tuser)
  );

  assign out_tdata = {(OutDataBits - 2 * FieldBits)'(0), pt_y, pt_x};

`ifndef SYNTHESIS
  // an empty-line result carries zero coordinates and closes its line
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("empty-line result malformed");

  // nothing is presented in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");
`endif

endmodule
